// ----- src/rts_pkg.sv -----
// ----------------------------------------------------------------------------
// rts_pkg
// shared types, codes and opcode decode of the region table slot engine
// ----------------------------------------------------------------------------
`default_nettype none

package rts_pkg;

  localparam int SLOTS_DEF = 256;

  // slot kinds, empty first
  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_BIG   = 2'd1;
  localparam logic [1:0] KIND_SMALL = 2'd2;
  localparam logic [1:0] KIND_HEAP  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_DUP  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // opcodes
  localparam logic [3:0] OP_INS_BIG   = 4'd0;
  localparam logic [3:0] OP_INS_SMALL = 4'd1;
  localparam logic [3:0] OP_INS_HEAP  = 4'd2;
  localparam logic [3:0] OP_SRC_BIG   = 4'd3;
  localparam logic [3:0] OP_SRC_SMALL = 4'd4;
  localparam logic [3:0] OP_SRC_HEAP  = 4'd5;
  localparam logic [3:0] OP_DEL_BIG   = 4'd6;
  localparam logic [3:0] OP_DEL_SMALL = 4'd7;
  localparam logic [3:0] OP_DEL_HEAP  = 4'd8;

  typedef enum logic [1:0] {
    ACT_INSERT,
    ACT_SEARCH,
    ACT_DELETE
  } action_t;

  typedef struct packed {
    logic       valid;
    action_t    action;
    logic [1:0] kind;
  } op_dec_t;

  typedef struct packed {
    logic [63:0] addr;
    logic [63:0] size;
    logic [63:0] heap_ref;
  } rec_t;

  function automatic op_dec_t op_decode(input logic [3:0] op);
    op_dec_t d;
    d = '{valid: 1'b1, action: ACT_INSERT, kind: KIND_BIG};
    unique case (op)
      OP_INS_BIG:   d = '{valid: 1'b1, action: ACT_INSERT, kind: KIND_BIG};
      OP_INS_SMALL: d = '{valid: 1'b1, action: ACT_INSERT, kind: KIND_SMALL};
      OP_INS_HEAP:  d = '{valid: 1'b1, action: ACT_INSERT, kind: KIND_HEAP};
      OP_SRC_BIG:   d = '{valid: 1'b1, action: ACT_SEARCH, kind: KIND_BIG};
      OP_SRC_SMALL: d = '{valid: 1'b1, action: ACT_SEARCH, kind: KIND_SMALL};
      OP_SRC_HEAP:  d = '{valid: 1'b1, action: ACT_SEARCH, kind: KIND_HEAP};
      OP_DEL_BIG:   d = '{valid: 1'b1, action: ACT_DELETE, kind: KIND_BIG};
      OP_DEL_SMALL: d = '{valid: 1'b1, action: ACT_DELETE, kind: KIND_SMALL};
      OP_DEL_HEAP:  d = '{valid: 1'b1, action: ACT_DELETE, kind: KIND_HEAP};
      default:      d = '{valid: 1'b0, action: ACT_INSERT, kind: KIND_EMPTY};
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- src/region_table_slot_engine_top.sv -----
// flow: an unused opcode goes straight to the result register; any other transaction walks
//   the pool at one slot a cycle, stopping at a hit, then decides, pops a free slot for an insert
//   or fetches the hit record for a search, and registers the result once the output register is free
// issue: one transaction at a time, the next is taken the cycle after the result is
//   registered; the scan through the single read port sets the pace
// reset: synchronous, active low; after reset and after every active_slots write a clearing
//   pass over every slot empties the slots and rebuilds the free stack, no input meanwhile
// ----------------------------------------------------------------------------
// region_table_slot_engine_top
// keyed record tables (big/small regions, heap) over a shared slot pool with a free stack
// ----------------------------------------------------------------------------
`default_nettype none

module region_table_slot_engine_top #(
  parameter int SLOTS = rts_pkg::SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_opcode,
  input  wire logic [63:0] in_key,
  input  wire logic [63:0] in_region_addr,
  input  wire logic [63:0] in_region_size,
  input  wire logic [63:0] in_heap_ref,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [7:0]       out_slot,
  output logic [63:0]      out_found_addr,
  output logic [63:0]      out_found_size,
  output logic [63:0]      out_found_heap_ref,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import rts_pkg::*;

  localparam int AW = $clog2(SLOTS);      // slot index width
  localparam int CW = $clog2(SLOTS + 1);  // free count width, holds SLOTS itself
  localparam int SW = (AW > 8) ? AW : 8;  // room to take the low byte of an index

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_POP,
    S_FETCH,
    S_OUT
  } state_t;

  // slot memories, one write and one registered read port each
  logic [1:0]    kind_mem [SLOTS];
  logic [63:0]   key_mem  [SLOTS];
  rec_t          rec_mem  [SLOTS];
  logic [AW-1:0] fs_mem   [SLOTS];

  logic [1:0]    kind_rd_r;
  logic [63:0]   key_rd_r;
  rec_t          rec_rd_r;
  logic [AW-1:0] fs_rd_r;

  state_t        st_r;
  logic [8:0]    active_r;
  logic [CW-1:0] free_cnt_r;
  logic [AW-1:0] clr_idx_r;

  // accepted transaction
  op_dec_t       op_r;
  logic [63:0]   key_r;
  rec_t          new_rec_r;

  // scan pipeline
  logic [CW-1:0] scan_idx_r;
  logic          pend_vld_r;
  logic [AW-1:0] pend_idx_r;
  logic          hit_r;
  logic [AW-1:0] hit_idx_r;
  logic [1:0]    hit_kind_r;

  // pending result
  logic [1:0]    res_status_r;
  logic [AW-1:0] res_slot_r;
  rec_t          res_rec_r;

  // output register
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [7:0]    out_slot_r;
  rec_t          out_rec_r;

  // combinational controls
  logic          cfg_wr;
  logic [8:0]    cfg_val;
  logic [CW-1:0] pool_n;
  logic [CW-1:0] clr_top;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] fcm1;
  logic [AW-1:0] fs_rd_addr;
  logic          match;
  logic          kind_match;
  logic          kind_we;
  logic [AW-1:0] kind_wa;
  logic [1:0]    kind_wd;
  logic          rec_we;
  logic          fs_we;
  logic [AW-1:0] fs_wa;
  logic [AW-1:0] fs_wd;
  logic [SW-1:0] slot_ext;
  op_dec_t       in_dec;

  // register write: the whole two-bit address is decoded, only address zero exists
  assign cfg_wr  = psel && penable && pwrite && (paddr == 2'b00);
  assign cfg_val = ({23'b0, pwdata[8:0]} > 32'(SLOTS)) ? 9'(SLOTS) : pwdata[8:0];
  assign pready  = 1'b1;
  assign prdata  = (paddr == 2'b00) ? {23'b0, active_r} : 32'b0;

  // pool size with saturation at the slot count
  assign pool_n  = ({23'b0, active_r} > 32'(SLOTS)) ? CW'(SLOTS) : CW'(active_r);
  assign clr_top = pool_n - CW'(1) - CW'(clr_idx_r);

  assign in_dec = op_decode(in_opcode);

  // one address for the kind, key and record memories: scan position, or the hit when fetching
  assign rd_addr    = (st_r == S_DECIDE) ? hit_idx_r : scan_idx_r[AW-1:0];
  assign fcm1       = free_cnt_r - CW'(1);
  assign fs_rd_addr = fcm1[AW-1:0];

  // region table sees big and small, heap table sees heap only
  assign match = pend_vld_r && (kind_rd_r != KIND_EMPTY)
              && ((kind_rd_r == KIND_HEAP) == (op_r.kind == KIND_HEAP))
              && (key_rd_r == key_r);
  assign kind_match = hit_r && (hit_kind_r == op_r.kind);

  always_comb begin
    kind_we = 1'b0;
    kind_wa = clr_idx_r;
    kind_wd = KIND_EMPTY;
    rec_we  = 1'b0;
    fs_we   = 1'b0;
    fs_wa   = clr_idx_r;
    fs_wd   = clr_top[AW-1:0];
    unique case (st_r)
      S_CLEAR: begin
        kind_we = 1'b1;
        fs_we   = 1'b1;
      end
      S_POP: begin
        kind_we = 1'b1;
        kind_wa = fs_rd_r;
        kind_wd = op_r.kind;
        rec_we  = 1'b1;
      end
      S_DECIDE: begin
        if (op_r.action == ACT_DELETE && kind_match) begin
          kind_we = 1'b1;
          kind_wa = hit_idx_r;
          // push the freed slot back on top of the stack
          fs_we   = ({{(32-CW){1'b0}}, free_cnt_r} < 32'(SLOTS));
          fs_wa   = free_cnt_r[AW-1:0];
          fs_wd   = hit_idx_r;
        end
      end
      default: begin
      end
    endcase
  end

  // slot memories
  always_ff @(posedge clk) begin
    if (kind_we) begin
      kind_mem[kind_wa] <= kind_wd;
    end
    if (rec_we) begin
      key_mem[fs_rd_r] <= key_r;
      rec_mem[fs_rd_r] <= new_rec_r;
    end
    if (fs_we) begin
      fs_mem[fs_wa] <= fs_wd;
    end
    kind_rd_r <= kind_mem[rd_addr];
    key_rd_r  <= key_mem[rd_addr];
    rec_rd_r  <= rec_mem[rd_addr];
    fs_rd_r   <= fs_mem[fs_rd_addr];
  end

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      active_r    <= 9'd256;
      clr_idx_r   <= '0;
      free_cnt_r  <= '0;
      scan_idx_r  <= '0;
      pend_vld_r  <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // result taken; a new one loaded in S_OUT overrides this
      if (out_valid_r && out_ready && (st_r != S_OUT || cfg_wr)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        // register write rebuilds the pool
        active_r  <= cfg_val;
        clr_idx_r <= '0;
        st_r      <= S_CLEAR;
      end else begin
        unique case (st_r)
          S_CLEAR: begin
            clr_idx_r <= clr_idx_r + AW'(1);
            if (clr_idx_r == AW'(SLOTS - 1)) begin
              free_cnt_r <= pool_n;
              st_r       <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_valid) begin
              op_r      <= in_dec;
              key_r     <= in_key;
              new_rec_r <= '{addr: in_region_addr, size: in_region_size,
                             heap_ref: (in_dec.kind == KIND_SMALL) ? in_heap_ref : 64'b0};
              scan_idx_r <= '0;
              pend_vld_r <= 1'b0;
              hit_r      <= 1'b0;
              if (!in_dec.valid) begin
                res_status_r <= ST_MISS;
                res_slot_r   <= '0;
                res_rec_r    <= '0;
                st_r         <= S_OUT;
              end else begin
                st_r <= S_SCAN;
              end
            end
          end
          S_SCAN: begin
            pend_vld_r <= ({{(32-CW){1'b0}}, scan_idx_r} < 32'(SLOTS));
            pend_idx_r <= scan_idx_r[AW-1:0];
            if ({{(32-CW){1'b0}}, scan_idx_r} < 32'(SLOTS)) begin
              scan_idx_r <= scan_idx_r + CW'(1);
            end
            priority if (match) begin
              hit_r      <= 1'b1;
              hit_idx_r  <= pend_idx_r;
              hit_kind_r <= kind_rd_r;
              st_r       <= S_DECIDE;
            end else if (pend_vld_r && pend_idx_r == AW'(SLOTS - 1)) begin
              st_r <= S_DECIDE;
            end
          end
          S_DECIDE: begin
            res_status_r <= ST_MISS;
            res_slot_r   <= '0;
            res_rec_r    <= '0;
            st_r         <= S_OUT;
            unique case (op_r.action)
              ACT_INSERT: begin
                priority if (hit_r) begin
                  res_status_r <= ST_DUP;
                end else if (free_cnt_r == '0) begin
                  res_status_r <= ST_FULL;
                end else begin
                  st_r <= S_POP;
                end
              end
              ACT_SEARCH: begin
                if (kind_match) begin
                  st_r <= S_FETCH;
                end
              end
              ACT_DELETE: begin
                if (kind_match) begin
                  res_status_r <= ST_OK;
                  res_slot_r   <= hit_idx_r;
                  if ({{(32-CW){1'b0}}, free_cnt_r} < 32'(SLOTS)) begin
                    free_cnt_r <= free_cnt_r + CW'(1);
                  end
                end
              end
              default: begin
              end
            endcase
          end
          S_POP: begin
            free_cnt_r   <= fcm1;
            res_status_r <= ST_OK;
            res_slot_r   <= fs_rd_r;
            res_rec_r    <= '0;
            st_r         <= S_OUT;
          end
          S_FETCH: begin
            res_status_r <= ST_OK;
            res_slot_r   <= hit_idx_r;
            res_rec_r    <= rec_rd_r;
            st_r         <= S_OUT;
          end
          S_OUT: begin
            if (!out_valid_r || out_ready) begin
              out_valid_r  <= 1'b1;
              out_status_r <= res_status_r;
              out_slot_r   <= slot_ext[7:0];
              out_rec_r    <= res_rec_r;
              st_r         <= S_IDLE;
            end
          end
          default: begin
            st_r <= S_CLEAR;
          end
        endcase
      end
    end
  end

  assign slot_ext = SW'(res_slot_r);

  assign in_ready           = (st_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_slot           = out_slot_r;
  assign out_found_addr     = out_rec_r.addr;
  assign out_found_size     = out_rec_r.size;
  assign out_found_heap_ref = out_rec_r.heap_ref;

  // free count never passes the slot count
  a_free_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    {{(32-CW){1'b0}}, free_cnt_r} <= 32'(SLOTS))
    else $error("free count above pool size");

  // a slot is popped only from a non-empty stack
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_POP) |-> (free_cnt_r != '0))
    else $error("pop from empty free stack");

  // an accepted transaction always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (st_r != S_IDLE))
    else $error("sequencer stayed idle after accept");

endmodule

`default_nettype wire

// ----- sim/region_table_slot_engine_top_tb.sv -----
// ----------------------------------------------------------------------------
// region_table_slot_engine_top_tb
// self-checking bench: directed table then random keyed insert/search/delete
// traffic over several pool sizes and idling patterns, each result compared
// field by field against a behavioural slot pool kept alongside the design
// ----------------------------------------------------------------------------
`default_nettype none

module region_table_slot_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rts_pkg::*;

  localparam int POOL      = SLOTS_DEF;
  localparam int KEYS      = 24;
  localparam int SETTLE    = POOL + 16;     // scan latency plus margin
  localparam int LIMIT     = 2_500_000;
  localparam int IDLE_PCT  = 85;

  // idling patterns
  typedef enum logic [1:0] {
    MODE_FREE,
    MODE_SRC_IDLE,
    MODE_SNK_STALL,
    MODE_BOTH
  } idle_mode_t;

  typedef struct {
    logic [1:0]  status;
    logic [7:0]  slot;
    logic [63:0] addr;
    logic [63:0] size;
    logic [63:0] heap_ref;
  } result_t;

  typedef struct {
    logic [3:0]  op;
    logic [63:0] key;
    logic [63:0] addr;
    logic [63:0] size;
    logic [63:0] heap_ref;
    bit          typed;    // status and slot written into the row
    logic [1:0]  status;
    logic [7:0]  slot;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  in_opcode;
  logic [63:0] in_key;
  logic [63:0] in_region_addr;
  logic [63:0] in_region_size;
  logic [63:0] in_heap_ref;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [7:0]  out_slot;
  logic [63:0] out_found_addr;
  logic [63:0] out_found_size;
  logic [63:0] out_found_heap_ref;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  region_table_slot_engine_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_key            (in_key),
    .in_region_addr    (in_region_addr),
    .in_region_size    (in_region_size),
    .in_heap_ref       (in_heap_ref),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_found_addr    (out_found_addr),
    .out_found_size    (out_found_size),
    .out_found_heap_ref(out_found_heap_ref),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow slot pool: kinds, stored records and the free stack
  // ---------------------------------------------------------------------------
  logic [1:0]  pool_kind [POOL];
  logic [63:0] pool_key  [POOL];
  logic [63:0] pool_addr [POOL];
  logic [63:0] pool_size [POOL];
  logic [63:0] pool_href [POOL];
  int          free_stack [POOL];
  int          free_count;

  result_t     pending_results[$];
  idle_mode_t  idle_mode = MODE_FREE;
  int          cycles = 0;
  int          errors = 0;
  int          sent = 0;
  int          received = 0;
  int          status_seen [4];
  logic [63:0] key_set [KEYS];

  // writing active_slots empties the pool and rebuilds the stack, 0 on top
  function automatic void pool_rebuild(input logic [31:0] value);
    int n;
    n = int'(value[8:0]);
    if (n > POOL) n = POOL;
    for (int i = 0; i < POOL; i++) begin
      pool_kind[i]  = KIND_EMPTY;
      free_stack[i] = 0;
    end
    for (int i = 0; i < n; i++) free_stack[n - 1 - i] = i;
    free_count = n;
  endfunction

  // associative lookup in one key space: heap table or region table
  function automatic int pool_lookup(input bit heap_space, input logic [63:0] key);
    for (int i = 0; i < POOL; i++) begin
      if (pool_kind[i] != KIND_EMPTY && ((pool_kind[i] == KIND_HEAP) == heap_space) &&
          pool_key[i] == key) return i;
    end
    return -1;
  endfunction

  // applies one transaction to the shadow pool and gives the expected answer
  function automatic result_t table_update(input logic [3:0] op, input logic [63:0] key,
                                           input logic [63:0] addr, input logic [63:0] size,
                                           input logic [63:0] href);
    result_t r;
    action_t act;
    logic [1:0] kind;
    bit known;
    int hit;
    int s;
    r = '{status: ST_MISS, slot: 8'd0, addr: '0, size: '0, heap_ref: '0};
    known = 1'b1;
    act = ACT_INSERT;
    kind = KIND_EMPTY;
    case (op)
      OP_INS_BIG:   begin act = ACT_INSERT; kind = KIND_BIG;   end
      OP_INS_SMALL: begin act = ACT_INSERT; kind = KIND_SMALL; end
      OP_INS_HEAP:  begin act = ACT_INSERT; kind = KIND_HEAP;  end
      OP_SRC_BIG:   begin act = ACT_SEARCH; kind = KIND_BIG;   end
      OP_SRC_SMALL: begin act = ACT_SEARCH; kind = KIND_SMALL; end
      OP_SRC_HEAP:  begin act = ACT_SEARCH; kind = KIND_HEAP;  end
      OP_DEL_BIG:   begin act = ACT_DELETE; kind = KIND_BIG;   end
      OP_DEL_SMALL: begin act = ACT_DELETE; kind = KIND_SMALL; end
      OP_DEL_HEAP:  begin act = ACT_DELETE; kind = KIND_HEAP;  end
      default:      known = 1'b0;
    endcase
    if (!known) return r;
    hit = pool_lookup(kind == KIND_HEAP, key);
    if (act == ACT_INSERT) begin
      // duplicate check comes before a slot is taken
      if (hit >= 0) begin
        r.status = ST_DUP;
      end else if (free_count == 0) begin
        r.status = ST_FULL;
      end else begin
        free_count--;
        s = free_stack[free_count];
        pool_kind[s] = kind;
        pool_key[s]  = key;
        pool_addr[s] = addr;
        pool_size[s] = size;
        pool_href[s] = (kind == KIND_SMALL) ? href : 64'd0;
        r.status = ST_OK;
        r.slot   = 8'(s);
      end
    end else if (hit >= 0 && pool_kind[hit] == kind) begin
      r.status = ST_OK;
      r.slot   = 8'(hit);
      if (act == ACT_SEARCH) begin
        r.addr     = pool_addr[hit];
        r.size     = pool_size[hit];
        r.heap_ref = pool_href[hit];
      end else begin
        pool_kind[hit] = KIND_EMPTY;
        if (free_count < POOL) begin
          free_stack[free_count] = hit;
          free_count++;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // stored fields: mostly random, sometimes the extremes
  function automatic logic [63:0] rand_field();
    case ($urandom_range(9))
      0:       return 64'd0;
      1:       return '1;
      default: return rand64();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // input side: one transaction per call, valid held across back-to-back items
  // ---------------------------------------------------------------------------
  task automatic send_item(input row_t row);
    result_t want;
    if (idle_mode == MODE_SRC_IDLE || idle_mode == MODE_BOTH) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_opcode      <= row.op;
    in_key         <= row.key;
    in_region_addr <= row.addr;
    in_region_size <= row.size;
    in_heap_ref    <= row.heap_ref;
    do @(posedge clk); while (!in_ready);
    // accepted at this edge: predict in acceptance order
    want = table_update(row.op, row.key, row.addr, row.size, row.heap_ref);
    if (row.typed) begin
      want.status = row.status;
      want.slot   = row.slot;
    end
    pending_results.push_back(want);
    sent++;
  endtask

  // register writes only with the engine idle
  task automatic write_active_slots(input logic [31:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 2'd0;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pool_rebuild(value);
  endtask

  task automatic random_phase(input logic [31:0] active, input idle_mode_t mode,
                              input int count);
    row_t row;
    write_active_slots(active);
    idle_mode = mode;
    for (int i = 0; i < KEYS; i++) key_set[i] = rand64();
    for (int i = 0; i < count; i++) begin
      // mostly legal opcodes over a small key set so hits, duplicates and
      // kind mismatches are frequent; the rest is unused opcodes and noise keys
      row.op       = ($urandom_range(99) < 6) ? 4'($urandom_range(15, 9))
                                              : 4'($urandom_range(8));
      row.key      = ($urandom_range(99) < 80) ? key_set[$urandom_range(KEYS - 1)]
                                               : rand64();
      row.addr     = rand_field();
      row.size     = rand_field();
      row.heap_ref = rand_field();
      row.typed    = 1'b0;
      row.status   = ST_OK;
      row.slot     = 8'd0;
      send_item(row);
    end
  endtask

  function automatic row_t mk(input logic [3:0] op, input logic [63:0] key,
                              input logic [63:0] addr, input logic [63:0] size,
                              input logic [63:0] href, input bit typed,
                              input logic [1:0] st, input logic [7:0] slot);
    row_t r;
    r = '{op: op, key: key, addr: addr, size: size, heap_ref: href,
          typed: typed, status: st, slot: slot};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls, in-order comparison
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      received++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d slot=%0d", $time, out_status, out_slot);
        errors++;
      end else begin
        result_t want;
        want = pending_results.pop_front();
        status_seen[want.status]++;
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          errors++;
        end
        if (out_slot !== want.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, want.slot, out_slot);
          errors++;
        end
        if (out_found_addr !== want.addr) begin
          $display("%0t: found_addr expected %h actual %h", $time, want.addr, out_found_addr);
          errors++;
        end
        if (out_found_size !== want.size) begin
          $display("%0t: found_size expected %h actual %h", $time, want.size, out_found_size);
          errors++;
        end
        if (out_found_heap_ref !== want.heap_ref) begin
          $display("%0t: found_heap_ref expected %h actual %h", $time, want.heap_ref,
                   out_found_heap_ref);
          errors++;
        end
      end
    end
    if (idle_mode == MODE_SNK_STALL || idle_mode == MODE_BOTH)
      out_ready <= ($urandom_range(99) >= IDLE_PCT);
    else
      out_ready <= 1'b1;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    row_t dir_rows[$];
    logic [63:0] ones;
    logic [63:0] alt;
    ones = '1;
    alt  = 64'h5555_5555_5555_5555;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = OP_INS_BIG;
    in_key         = '0;
    in_region_addr = '0;
    in_region_size = '0;
    in_heap_ref    = '0;
    out_ready      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = 2'd0;
    pwdata         = '0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    pool_rebuild(32'd256);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table after reset: full pool, slot 0 on top of the free stack
    dir_rows.push_back(mk(OP_INS_BIG,   64'd0, ones, ones, ones, 1, ST_OK,   8'd0));
    dir_rows.push_back(mk(OP_INS_SMALL, ones, 64'd0, 64'd0, ones, 1, ST_OK,  8'd1));
    // heap table has a key space of its own
    dir_rows.push_back(mk(OP_INS_HEAP,  64'd0, alt, ~alt, ones, 1, ST_OK,    8'd2));
    // duplicate key in the region space, whichever region kind
    dir_rows.push_back(mk(OP_INS_BIG,   64'd0, alt, alt, alt, 1, ST_DUP,     8'd0));
    dir_rows.push_back(mk(OP_INS_SMALL, 64'd0, alt, alt, alt, 1, ST_DUP,     8'd0));
    // kind mismatch reads as a miss
    dir_rows.push_back(mk(OP_SRC_SMALL, 64'd0, '0, '0, '0, 1, ST_MISS,       8'd0));
    dir_rows.push_back(mk(OP_SRC_BIG,   64'd0, '0, '0, '0, 1, ST_OK,         8'd0));
    dir_rows.push_back(mk(OP_SRC_SMALL, ones, '0, '0, '0, 1, ST_OK,          8'd1));
    dir_rows.push_back(mk(OP_SRC_HEAP,  64'd0, '0, '0, '0, 1, ST_OK,         8'd2));
    dir_rows.push_back(mk(OP_DEL_BIG,   ones, '0, '0, '0, 1, ST_MISS,        8'd0));
    dir_rows.push_back(mk(OP_DEL_SMALL, ones, '0, '0, '0, 1, ST_OK,          8'd1));
    dir_rows.push_back(mk(OP_SRC_SMALL, ones, '0, '0, '0, 1, ST_MISS,        8'd0));
    // freed slot goes back on top and is reused first
    dir_rows.push_back(mk(OP_INS_HEAP,  64'd5, ones, 64'd0, ones, 1, ST_OK,  8'd1));
    dir_rows.push_back(mk(OP_SRC_HEAP,  64'd5, '0, '0, '0, 0, ST_OK,         8'd0));
    // unused opcodes
    dir_rows.push_back(mk(4'd9,  64'd5, ones, ones, ones, 1, ST_MISS,        8'd0));
    dir_rows.push_back(mk(4'd15, 64'd0, ones, ones, ones, 1, ST_MISS,        8'd0));
    dir_rows.push_back(mk(OP_DEL_HEAP,  64'd0, '0, '0, '0, 1, ST_OK,         8'd2));
    dir_rows.push_back(mk(OP_DEL_HEAP,  64'd0, '0, '0, '0, 1, ST_MISS,       8'd0));
    dir_rows.push_back(mk(OP_DEL_BIG,   alt, '0, '0, '0, 1, ST_MISS,         8'd0));
    dir_rows.push_back(mk(OP_INS_SMALL, alt, ones, ones, ones, 1, ST_OK,     8'd2));
    dir_rows.push_back(mk(OP_SRC_SMALL, alt, '0, '0, '0, 0, ST_OK,           8'd0));
    dir_rows.push_back(mk(OP_SRC_BIG,   64'd0, '0, '0, '0, 0, ST_OK,         8'd0));
    @(posedge clk);
    foreach (dir_rows[i]) send_item(dir_rows[i]);

    // random phases over pool sizes: one slot, none, small, saturating, full
    random_phase(32'd256, MODE_FREE,       190);
    random_phase(32'd1,   MODE_SRC_IDLE,    60);
    random_phase(32'd0,   MODE_SNK_STALL,   30);
    random_phase(32'd8,   MODE_BOTH,       200);
    random_phase(32'd511, MODE_FREE,       180);
    random_phase(32'd16,  MODE_SNK_STALL,  150);
    random_phase(32'h203, MODE_SRC_IDLE,   100);   // upper bits dropped: three slots
    random_phase(32'd256, MODE_BOTH,       110);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d transactions, %0d results over pool sizes 0 to 256", sent, received);
    $display("statuses seen: ok %0d, miss %0d, duplicate %0d, full %0d",
             status_seen[ST_OK], status_seen[ST_MISS], status_seen[ST_DUP],
             status_seen[ST_FULL]);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- region_table_slot_engine_top.f -----
src/rts_pkg.sv
src/region_table_slot_engine_top.sv
sim/region_table_slot_engine_top_tb.sv
